// ===== hdl/bgcdm_pkg.sv =====
// Shared constants, beat types and control types for the multi-limb binary gcd.
package bgcdm_pkg;

  localparam int LIMBS   = 4;
  localparam int LIMB_W  = 64;
  localparam int IDX_W   = (LIMBS > 1) ? $clog2(LIMBS) : 1;
  localparam int CNT_W   = $clog2(LIMBS + 1);
  localparam int SHIFT_W = $clog2(LIMBS * LIMB_W + 1);
  localparam int NXT     = (LIMBS > 1) ? 1 : 0;

  typedef logic [LIMBS-1:0][LIMB_W-1:0] limb_vec_t;

  typedef struct packed {
    logic [LIMB_W-1:0] a_limb;
    logic [LIMB_W-1:0] b_limb;
    logic              last_limb;
  } in_beat_t;

  typedef struct packed {
    logic [LIMB_W-1:0] gcd_limb;
    logic              last_out;
  } out_beat_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_HALVE_AB,
    OP_HALVE_A,
    OP_HALVE_B,
    OP_SUB_BA,
    OP_SWAP_SUB,
    OP_SHL_A
  } pass_op_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PASS,
    ST_DECIDE,
    ST_HANDOFF
  } state_t;

  typedef enum logic [2:0] {
    PH_INIT,
    PH_TWOS,
    PH_ODDA,
    PH_LOOP,
    PH_SHL
  } phase_t;

  typedef struct packed {
    logic             load;
    logic [IDX_W-1:0] load_idx;
    logic             clear;
    logic             step;
    logic             first;
    logic             last;
    pass_op_t         op;
  } dp_ctrl_t;

  typedef struct packed {
    logic a_zero;
    logic b_zero;
    logic a_gt_b;
    logic a_lsb;
    logic b_lsb;
  } flags_t;

endpackage

// ===== hdl/bgcdm_datapath.sv =====
// Operand rotators with the one-limb-per-cycle halve, subtract, shift and flag logic.
module bgcdm_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  bgcdm_pkg::dp_ctrl_t  ctl,
  input  bgcdm_pkg::in_beat_t  load_beat,
  output bgcdm_pkg::limb_vec_t a_vec,
  output bgcdm_pkg::limb_vec_t b_vec,
  output bgcdm_pkg::flags_t    flags
);
  import bgcdm_pkg::*;

  limb_vec_t         a;
  limb_vec_t         b;
  logic              borrow;
  logic              carry;
  flags_t            fl;

  logic [LIMB_W-1:0] a0;
  logic [LIMB_W-1:0] b0;
  logic              hi_a;
  logic              hi_b;
  logic [LIMB_W-1:0] half_a;
  logic [LIMB_W-1:0] half_b;
  logic              bin;
  logic              cin;
  logic [LIMB_W:0]   diff_ba;
  logic [LIMB_W:0]   diff_ab;
  logic [LIMB_W-1:0] shl_a;
  logic [LIMB_W-1:0] na;
  logic [LIMB_W-1:0] nb;
  logic              borrow_next;
  logic              carry_next;
  logic              gt_next;

  always_comb begin
    a0      = a[0];
    b0      = b[0];
    hi_a    = ctl.last ? 1'b0 : a[NXT][0];
    hi_b    = ctl.last ? 1'b0 : b[NXT][0];
    half_a  = {hi_a, a0[LIMB_W-1:1]};
    half_b  = {hi_b, b0[LIMB_W-1:1]};
    bin     = ctl.first ? 1'b0 : borrow;
    cin     = ctl.first ? 1'b0 : carry;
    diff_ba = {1'b0, b0} - {1'b0, a0} - {{LIMB_W{1'b0}}, bin};
    diff_ab = {1'b0, a0} - {1'b0, b0} - {{LIMB_W{1'b0}}, bin};
    shl_a   = {a0[LIMB_W-2:0], cin};
  end

  always_comb begin
    na          = a0;
    nb          = b0;
    borrow_next = borrow;
    carry_next  = carry;
    case (ctl.op)
      OP_HOLD: begin
        na = a0;
        nb = b0;
      end
      OP_HALVE_AB: begin
        na = half_a;
        nb = half_b;
      end
      OP_HALVE_A: begin
        na = half_a;
      end
      OP_HALVE_B: begin
        nb = half_b;
      end
      OP_SUB_BA: begin
        nb          = diff_ba[LIMB_W-1:0];
        borrow_next = diff_ba[LIMB_W];
      end
      OP_SWAP_SUB: begin
        na          = b0;
        nb          = diff_ab[LIMB_W-1:0];
        borrow_next = diff_ab[LIMB_W];
      end
      OP_SHL_A: begin
        na         = shl_a;
        carry_next = a0[LIMB_W-1];
      end
      default: begin
        na = a0;
        nb = b0;
      end
    endcase
    gt_next = (na != nb) ? (na > nb) : (ctl.first ? 1'b0 : fl.a_gt_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a <= '0;
      b <= '0;
    end else if (ctl.clear) begin
      a <= '0;
      b <= '0;
    end else if (ctl.load) begin
      a[ctl.load_idx] <= load_beat.a_limb;
      b[ctl.load_idx] <= load_beat.b_limb;
    end else if (ctl.step) begin
      for (int i = 0; i < LIMBS - 1; i++) begin
        a[i] <= a[i+1];
        b[i] <= b[i+1];
      end
      a[LIMBS-1] <= na;
      b[LIMBS-1] <= nb;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      borrow    <= borrow_next;
      carry     <= carry_next;
      fl.a_gt_b <= gt_next;
      fl.a_zero <= (na == '0) & (ctl.first | fl.a_zero);
      fl.b_zero <= (nb == '0) & (ctl.first | fl.b_zero);
      fl.a_lsb  <= ctl.first ? na[0] : fl.a_lsb;
      fl.b_lsb  <= ctl.first ? nb[0] : fl.b_lsb;
    end
  end

  assign a_vec = a;
  assign b_vec = b;
  assign flags = fl;

endmodule

// ===== hdl/bgcdm_ctrl.sv =====
// Sequencer for operand loading, gcd passes and hand-off to the result buffer.
module bgcdm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_ready,
  input  bgcdm_pkg::flags_t   flags,
  input  logic                res_busy,
  output bgcdm_pkg::dp_ctrl_t ctl,
  output logic                copy_en,
  output logic                sel_b
);
  import bgcdm_pkg::*;

  state_t             state;
  state_t             state_next;
  phase_t             phase;
  phase_t             phase_next;
  pass_op_t           op;
  pass_op_t           op_next;
  logic [IDX_W-1:0]   cnt;
  logic [IDX_W-1:0]   cnt_next;
  logic [CNT_W-1:0]   pos;
  logic [CNT_W-1:0]   pos_next;
  logic [SHIFT_W-1:0] shift;
  logic [SHIFT_W-1:0] shift_next;
  logic               sel;
  logic               sel_next;
  logic               accept;
  logic               room;

  assign room   = pos < CNT_W'(LIMBS);
  assign accept = in_valid && (state == ST_LOAD);

  always_comb begin
    state_next = state;
    phase_next = phase;
    op_next    = op;
    cnt_next   = cnt;
    pos_next   = pos;
    shift_next = shift;
    sel_next   = sel;
    case (state)
      ST_LOAD: begin
        if (accept) begin
          if (room) begin
            pos_next = pos + CNT_W'(1);
          end
          if (in_last) begin
            state_next = ST_PASS;
            phase_next = PH_INIT;
            op_next    = OP_HOLD;
            cnt_next   = '0;
            shift_next = '0;
          end
        end
      end
      ST_PASS: begin
        if (cnt == IDX_W'(LIMBS - 1)) begin
          cnt_next   = '0;
          state_next = ST_DECIDE;
        end else begin
          cnt_next = cnt + IDX_W'(1);
        end
      end
      ST_DECIDE: begin
        case (phase)
          PH_INIT: begin
            if (flags.a_zero) begin
              sel_next   = 1'b1;
              state_next = ST_HANDOFF;
            end else if (flags.b_zero) begin
              sel_next   = 1'b0;
              state_next = ST_HANDOFF;
            end else begin
              phase_next = PH_TWOS;
            end
          end
          PH_TWOS: begin
            if (!flags.a_lsb && !flags.b_lsb) begin
              op_next    = OP_HALVE_AB;
              shift_next = shift + SHIFT_W'(1);
              state_next = ST_PASS;
            end else begin
              phase_next = PH_ODDA;
            end
          end
          PH_ODDA: begin
            if (!flags.a_lsb) begin
              op_next    = OP_HALVE_A;
              state_next = ST_PASS;
            end else begin
              phase_next = PH_LOOP;
            end
          end
          PH_LOOP: begin
            if (flags.b_zero) begin
              phase_next = PH_SHL;
            end else if (!flags.b_lsb) begin
              op_next    = OP_HALVE_B;
              state_next = ST_PASS;
            end else if (flags.a_gt_b) begin
              op_next    = OP_SWAP_SUB;
              state_next = ST_PASS;
            end else begin
              op_next    = OP_SUB_BA;
              state_next = ST_PASS;
            end
          end
          PH_SHL: begin
            if (shift == '0) begin
              sel_next   = 1'b0;
              state_next = ST_HANDOFF;
            end else begin
              shift_next = shift - SHIFT_W'(1);
              op_next    = OP_SHL_A;
              state_next = ST_PASS;
            end
          end
          default: begin
            phase_next = PH_INIT;
          end
        endcase
      end
      ST_HANDOFF: begin
        if (!res_busy) begin
          pos_next   = '0;
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    in_ready     = (state == ST_LOAD);
    copy_en      = (state == ST_HANDOFF) && !res_busy;
    sel_b        = sel;
    ctl.load     = accept && room;
    ctl.load_idx = pos[IDX_W-1:0];
    ctl.clear    = copy_en;
    ctl.step     = (state == ST_PASS);
    ctl.first    = (cnt == '0);
    ctl.last     = (cnt == IDX_W'(LIMBS - 1));
    ctl.op       = op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      phase <= PH_INIT;
      op    <= OP_HOLD;
      cnt   <= '0;
      pos   <= '0;
      shift <= '0;
      sel   <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      op    <= op_next;
      cnt   <= cnt_next;
      pos   <= pos_next;
      shift <= shift_next;
      sel   <= sel_next;
    end
  end

endmodule

// ===== hdl/bgcdm_resbuf.sv =====
// Result limb buffer that drains one gcd limb per output beat.
module bgcdm_resbuf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  copy_en,
  input  bgcdm_pkg::limb_vec_t  src,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bgcdm_pkg::out_beat_t  out_data,
  output logic                  busy
);
  import bgcdm_pkg::*;

  limb_vec_t        res;
  logic [IDX_W-1:0] cnt;
  logic             valid;
  logic             at_last;

  assign at_last = (cnt == IDX_W'(LIMBS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      cnt   <= '0;
    end else if (copy_en) begin
      valid <= 1'b1;
      cnt   <= '0;
    end else if (valid && out_ready) begin
      cnt <= cnt + IDX_W'(1);
      if (at_last) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (copy_en) begin
      res <= src;
    end else if (valid && out_ready) begin
      for (int i = 0; i < LIMBS - 1; i++) begin
        res[i] <= res[i+1];
      end
    end
  end

  always_comb begin
    out_valid         = valid;
    busy              = valid;
    out_data.gcd_limb = res[0];
    out_data.last_out = at_last;
  end

endmodule

// ===== hdl/binary_gcd_multiword.sv =====
// Top level of the multi-limb binary gcd: loader, sequencer, datapath and result buffer.
//
//   channel  dir  beat type   handshake             content
//   in       in   in_beat_t   in_valid / in_ready   a and b limb pair, last_limb mark
//   out      out  out_beat_t  out_valid / out_ready gcd limb, last_out on the top limb
//
// One in beat per cycle while loading; in_ready drops from the last_limb beat until hand-off.
// Compute on 256-bit operands runs in passes over all LIMBS limbs, each followed by a decision
// state, with the one-limb-per-cycle subtract and shift unit in the datapath.
// The LIMBS result beats drain from their own buffer while the next operands load.
// Reset clears the sequencer, the result buffer state and both operand stores.
module binary_gcd_multiword (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bgcdm_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bgcdm_pkg::out_beat_t out_data
);
  import bgcdm_pkg::*;

  dp_ctrl_t  ctl;
  flags_t    flags;
  limb_vec_t a_vec;
  limb_vec_t b_vec;
  limb_vec_t res_src;
  logic      copy_en;
  logic      sel_b;
  logic      res_busy;

  assign res_src = sel_b ? b_vec : a_vec;

  bgcdm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (in_data.last_limb),
    .in_ready (in_ready),
    .flags    (flags),
    .res_busy (res_busy),
    .ctl      (ctl),
    .copy_en  (copy_en),
    .sel_b    (sel_b)
  );

  bgcdm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .load_beat (in_data),
    .a_vec     (a_vec),
    .b_vec     (b_vec),
    .flags     (flags)
  );

  bgcdm_resbuf u_resbuf (
    .clk       (clk),
    .rst       (rst),
    .copy_en   (copy_en),
    .src       (res_src),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .busy      (res_busy)
  );

`ifndef SYNTHESIS
  a_copy_into_empty: assert property (@(posedge clk) disable iff (rst)
    copy_en |-> !res_busy)
    else $error("result copied over undrained beats");

  a_last_in_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.last_limb |=> !in_ready)
    else $error("input taken after last limb beat");

  a_last_out_drains: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.last_out |=> !out_valid)
    else $error("output still valid after last result beat");
`endif

endmodule

// ===== bench/binary_gcd_multiword_checker.sv =====
// Checker for the multi-limb binary gcd: watches both channels, predicts each gcd, compares.
`timescale 1ns / 1ps
module binary_gcd_multiword_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  bgcdm_pkg::in_beat_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  bgcdm_pkg::out_beat_t out_data,
  output int unsigned          mismatches,
  output int unsigned          pending,
  output int unsigned          gcd_count,
  output int unsigned          limbs_checked
);
  import bgcdm_pkg::*;

  typedef logic [LIMBS*LIMB_W-1:0] wide_t;

  limb_vec_t   a_store;
  limb_vec_t   b_store;
  int unsigned limbs_stored;
  int unsigned common_twos;
  int unsigned fail_count = 0;
  int unsigned gcd_total = 0;
  int unsigned beat_total = 0;
  out_beat_t   gcd_limb_q[$];

  task automatic report_mismatch(string what);
    fail_count++;
    $display("%0t gcd check: %s", $time, what);
  endtask

  function automatic wide_t stein_gcd(wide_t a, wide_t b, inout int unsigned twos);
    wide_t       t;
    int unsigned k;
    if (a == '0) return b;
    if (b == '0) return a;
    k = 0;
    while (!a[0] && !b[0]) begin
      a = a >> 1;
      b = b >> 1;
      k++;
    end
    twos = k;
    while (!a[0]) a = a >> 1;
    while (b != '0) begin
      while (!b[0]) b = b >> 1;
      if (a > b) begin
        t = a;
        a = b;
        b = t;
      end
      b = b - a;
    end
    return a << k;
  endfunction

  always @(posedge clk) begin
    out_beat_t want;
    limb_vec_t gcd_val;
    if (rst) begin
      a_store = '0;
      b_store = '0;
      limbs_stored = 0;
      common_twos = 0;
      gcd_limb_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (gcd_limb_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat gcd_limb=%h last_out=%b",
                                    out_data.gcd_limb, out_data.last_out));
        end else begin
          want = gcd_limb_q.pop_front();
          beat_total++;
          if (out_data.gcd_limb !== want.gcd_limb)
            report_mismatch($sformatf("gcd_limb %h, expected %h",
                                      out_data.gcd_limb, want.gcd_limb));
          if (out_data.last_out !== want.last_out)
            report_mismatch($sformatf("last_out %b, expected %b",
                                      out_data.last_out, want.last_out));
        end
      end
      if (in_valid && in_ready) begin
        if (limbs_stored < LIMBS) begin
          a_store[limbs_stored] = in_data.a_limb;
          b_store[limbs_stored] = in_data.b_limb;
          limbs_stored++;
        end
        if (in_data.last_limb) begin
          gcd_val = stein_gcd(a_store, b_store, common_twos);
          for (int k = 0; k < LIMBS; k++)
            gcd_limb_q.push_back('{gcd_limb: gcd_val[k], last_out: (k == LIMBS - 1)});
          a_store = '0;
          b_store = '0;
          limbs_stored = 0;
          gcd_total++;
        end
      end
    end
    mismatches    <= fail_count;
    pending       <= gcd_limb_q.size();
    gcd_count     <= gcd_total;
    limbs_checked <= beat_total;
  end

endmodule

// ===== bench/binary_gcd_multiword_tb.sv =====
// Testbench top for the multi-limb binary gcd: clock, reset, operand stimulus and verdict.
`timescale 1ns / 1ps
module binary_gcd_multiword_tb;
  import bgcdm_pkg::*;

  typedef logic [LIMBS*LIMB_W-1:0] wide_t;

  localparam int unsigned RANDOM_BEATS = 160;
  localparam int unsigned HOLD_CYCLES  = 4000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_beat_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_beat_t   out_data;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned gcd_count;
  int unsigned limbs_checked;

  int unsigned beats_sent = 0;
  int unsigned burst_left = 0;
  logic        hold_off_req = 1'b0;
  int unsigned rx_mode = 0;
  int unsigned rx_mode_left = 0;
  int unsigned rx_tick = 0;

  binary_gcd_multiword u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  binary_gcd_multiword_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .mismatches    (mismatches),
    .pending       (pending),
    .gcd_count     (gcd_count),
    .limbs_checked (limbs_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic wide_t rand_wide(int unsigned bits);
    wide_t v;
    for (int i = 0; i < LIMBS * 2; i++) v[i*32 +: 32] = $urandom;
    if (bits < LIMBS * LIMB_W) v &= (wide_t'(1) << bits) - 1;
    return v;
  endfunction

  task automatic pace();
    int unsigned gap_len;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      case ($urandom_range(0, 9))
        0:       gap_len = $urandom_range(40, 300);
        1, 2, 3: gap_len = 0;
        default: gap_len = $urandom_range(1, 12);
      endcase
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      if (gap_len != 0) begin
        in_valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
  endtask

  task automatic send_set(wide_t a_val, wide_t b_val, int unsigned beats);
    in_beat_t beat;
    for (int k = 0; k < beats; k++) begin
      if (k < LIMBS) begin
        beat.a_limb = a_val[k*LIMB_W +: LIMB_W];
        beat.b_limb = b_val[k*LIMB_W +: LIMB_W];
      end else begin
        beat.a_limb = {$urandom, $urandom};
        beat.b_limb = {$urandom, $urandom};
      end
      beat.last_limb = (k == beats - 1);
      in_data  <= beat;
      in_valid <= 1'b1;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      if (k < LIMBS || beat.last_limb) beats_sent++;
      pace();
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic make_pair(output wide_t a_val, output wide_t b_val, output int unsigned beats);
    wide_t       g;
    wide_t       x;
    wide_t       y;
    int unsigned width;
    case ($urandom_range(0, 9))
      0:       beats = $urandom_range(LIMBS + 1, LIMBS + 2);
      1, 2:    beats = LIMBS;
      default: beats = $urandom_range(1, LIMBS);
    endcase
    width = LIMB_W * ((beats > LIMBS) ? LIMBS : beats);
    case ($urandom_range(0, 9))
      0: begin
        a_val = '0;
        b_val = rand_wide($urandom_range(0, width));
        if ($urandom_range(0, 1) == 1) begin
          g = a_val;
          a_val = b_val;
          b_val = g;
        end
      end
      1: begin
        a_val = rand_wide($urandom_range(1, width));
        b_val = a_val;
      end
      2, 3: begin
        g = rand_wide($urandom_range(1, 40)) << $urandom_range(0, 40);
        x = rand_wide($urandom_range(1, width / 2));
        y = rand_wide($urandom_range(1, width / 2));
        a_val = g * x;
        b_val = g * y;
      end
      4: begin
        a_val = wide_t'(1) << $urandom_range(0, width - 1);
        b_val = wide_t'(1) << $urandom_range(0, width - 1);
      end
      5: begin
        a_val = ~wide_t'(0) >> (LIMBS * LIMB_W - $urandom_range(1, width));
        b_val = rand_wide($urandom_range(1, width));
      end
      default: begin
        a_val = rand_wide($urandom_range(1, width)) << $urandom_range(0, 8);
        b_val = rand_wide($urandom_range(1, width)) << $urandom_range(0, 8);
      end
    endcase
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode      = $urandom_range(0, 3);
          rx_mode_left = $urandom_range(20, 200);
        end
        rx_mode_left--;
        rx_tick++;
        case (rx_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= (rx_tick % 4 == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    #20ms;
    $display("[binary_gcd_multiword] ERROR");
    $finish;
  end

  initial begin
    wide_t       a_val;
    wide_t       b_val;
    int unsigned beats;
    int unsigned random_start;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_set('0, '0, 1);
    send_set('0, wide_t'({LIMB_W{1'b1}}), 1);
    send_set(wide_t'({LIMB_W{1'b1}}), '0, 1);
    send_set(wide_t'(1) << (LIMBS * LIMB_W - 1), wide_t'(1) << (LIMBS * LIMB_W - 1), LIMBS);
    send_set(~wide_t'(0), ~wide_t'(0) - 1, LIMBS);
    send_set(rand_wide(LIMBS * LIMB_W), rand_wide(LIMBS * LIMB_W), LIMBS + 2);
    send_set(rand_wide(2 * LIMB_W), rand_wide(2 * LIMB_W), 2);
    send_set(wide_t'(1), rand_wide(LIMB_W) << 1, 1);
    a_val = rand_wide(LIMB_W) | 1;
    send_set(a_val, a_val, 1);
    wait_drain();

    hold_off_req = 1'b1;
    for (int i = 0; i < 3; i++) send_set(rand_wide(16) | 1, rand_wide(16), 1);
    wait_drain();

    random_start = beats_sent;
    while (beats_sent - random_start < RANDOM_BEATS) begin
      make_pair(a_val, b_val, beats);
      send_set(a_val, b_val, beats);
      if ($urandom_range(0, 24) == 0) wait_drain();
    end
    wait_drain();
    repeat (50) @(posedge clk);

    $display("covered %0d limb beats and %0d gcds (%0d result limbs), with zero, equal,",
             beats_sent, gcd_count, limbs_checked);
    $display("power-of-two, shared-factor and overlong operands, a long output stall and drains");
    if (mismatches == 0 && pending == 0) begin
      $display("[binary_gcd_multiword] OK");
    end else begin
      $display("[binary_gcd_multiword] ERROR");
    end
    $finish;
  end

endmodule

// ===== binary_gcd_multiword.f =====
hdl/bgcdm_pkg.sv
hdl/bgcdm_datapath.sv
hdl/bgcdm_ctrl.sv
hdl/bgcdm_resbuf.sv
hdl/binary_gcd_multiword.sv
bench/binary_gcd_multiword_checker.sv
bench/binary_gcd_multiword_tb.sv
